### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file cid_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define CID_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked during reset as well.
`define CID_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

### rtl/cid_pkg.sv
// ----------------------------------------------------------------------------
// cid_pkg
// Types and constants of the rounding integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

package cid_pkg;

    localparam int WIDTH    = 64;
    localparam int FIELD_W  = 64;
    localparam int ACTION_W = 3;

    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_TRUNC_Q = 3'd0;
    localparam t_action ACT_FLOOR_Q = 3'd1;
    localparam t_action ACT_CEIL_Q  = 3'd2;
    localparam t_action ACT_FLOOR_R = 3'd3;
    localparam t_action ACT_CEIL_R  = 3'd4;

    typedef logic [WIDTH-1:0] t_word;

    typedef struct packed {
        t_action action;
        logic    nx;
        logic    ny;
        logic    dz;
        logic    minneg;
    } t_meta;

    typedef struct packed {
        logic  valid;
        t_meta meta;
        t_word rem;
        t_word dq;   // dividend bits still to go, quotient bits shifted in below
        t_word ay;
    } t_stage;

    function automatic logic [FIELD_W-1:0] sext(input t_word v);
        return FIELD_W'(signed'(v));
    endfunction

endpackage

`default_nettype wire

### rtl/cid_if.sv
// ----------------------------------------------------------------------------
// cid_req_if / cid_rsp_if
// Valid/ready channels of the rounding integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

interface cid_req_if;
    logic                     valid;
    logic                     ready;
    cid_pkg::t_action         action;
    logic signed [63:0]       dividend;
    logic signed [63:0]       divisor;

    modport source (output valid, action, dividend, divisor, input ready);
    modport sink   (input valid, action, dividend, divisor, output ready);
endinterface

interface cid_rsp_if;
    logic                     valid;
    logic                     ready;
    logic signed [63:0]       outcome;
    logic                     overflowed;
    logic                     by_zero;

    modport source (output valid, outcome, overflowed, by_zero, input ready);
    modport sink   (input valid, outcome, overflowed, by_zero, output ready);
endinterface

`default_nettype wire

### rtl/cid_front.sv
// ----------------------------------------------------------------------------
// cid_front
// Operand magnitudes, signs and special-case flags ahead of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_front (
    input  wire logic                 i_valid,
    input  wire cid_pkg::t_action     i_action,
    input  wire logic [63:0]          i_dividend,
    input  wire logic [63:0]          i_divisor,
    output cid_pkg::t_stage           o_stage
);

    cid_pkg::t_word x;
    cid_pkg::t_word y;
    cid_pkg::t_word ax;
    cid_pkg::t_word ay;
    cid_pkg::t_word min_val;

    always_comb begin
        x       = i_dividend[cid_pkg::WIDTH-1:0];
        y       = i_divisor[cid_pkg::WIDTH-1:0];
        min_val = {1'b1, {(cid_pkg::WIDTH-1){1'b0}}};
        ax      = x[cid_pkg::WIDTH-1] ? (~x + 1'b1) : x;
        ay      = y[cid_pkg::WIDTH-1] ? (~y + 1'b1) : y;

        o_stage.valid       = i_valid;
        o_stage.meta.action = i_action;
        o_stage.meta.nx     = x[cid_pkg::WIDTH-1];
        o_stage.meta.ny     = y[cid_pkg::WIDTH-1];
        o_stage.meta.dz     = (y == '0);
        o_stage.meta.minneg = (x == min_val) && (y == '1);
        o_stage.rem         = '0;
        o_stage.dq          = ax;
        o_stage.ay          = ay;
    end

endmodule

`default_nettype wire

### rtl/cid_cell.sv
// ----------------------------------------------------------------------------
// cid_cell
// One restoring-division step: retires one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire cid_pkg::t_stage  i_stage,
    output cid_pkg::t_stage       o_stage
);

    cid_pkg::t_stage              r_stage;
    cid_pkg::t_stage              n_stage;
    logic [cid_pkg::WIDTH:0]      trial;
    logic [cid_pkg::WIDTH:0]      diff;
    logic                         fits;

    always_comb begin
        trial   = {i_stage.rem, i_stage.dq[cid_pkg::WIDTH-1]};
        diff    = trial - {1'b0, i_stage.ay};
        fits    = !diff[cid_pkg::WIDTH];
        n_stage = i_stage;
        n_stage.rem = fits ? diff[cid_pkg::WIDTH-1:0] : trial[cid_pkg::WIDTH-1:0];
        n_stage.dq  = {i_stage.dq[cid_pkg::WIDTH-2:0], fits};
    end

    // only the valid bit is cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

### rtl/cid_back.sv
// ----------------------------------------------------------------------------
// cid_back
// Sign restore and floor/ceiling rounding of the raw quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_back (
    input  wire cid_pkg::t_stage  i_stage,
    output logic [63:0]           o_outcome,
    output logic                  o_overflowed,
    output logic                  o_by_zero
);

    cid_pkg::t_word q;
    cid_pkg::t_word r;
    cid_pkg::t_word res;
    cid_pkg::t_word ay_m_rm;
    cid_pkg::t_word rm_m_ay;
    logic           differ;
    logic           rnz;
    logic           quot_mode;

    always_comb begin
        differ    = i_stage.meta.nx ^ i_stage.meta.ny;
        rnz       = (i_stage.rem != '0);
        q         = differ ? (~i_stage.dq + 1'b1) : i_stage.dq;
        r         = i_stage.meta.nx ? (~i_stage.rem + 1'b1) : i_stage.rem;
        ay_m_rm   = i_stage.ay - i_stage.rem;
        rm_m_ay   = i_stage.rem - i_stage.ay;
        quot_mode = (i_stage.meta.action == cid_pkg::ACT_TRUNC_Q)
                 || (i_stage.meta.action == cid_pkg::ACT_FLOOR_Q)
                 || (i_stage.meta.action == cid_pkg::ACT_CEIL_Q);

        unique case (i_stage.meta.action)
            cid_pkg::ACT_TRUNC_Q: res = q;
            cid_pkg::ACT_FLOOR_Q: res = (differ && rnz) ? ~i_stage.dq : q;
            cid_pkg::ACT_CEIL_Q:  res = (!differ && rnz) ? (i_stage.dq + 1'b1) : q;
            cid_pkg::ACT_FLOOR_R: begin
                if (differ && rnz) begin
                    res = i_stage.meta.nx ? ay_m_rm : rm_m_ay;
                end else begin
                    res = r;
                end
            end
            cid_pkg::ACT_CEIL_R: begin
                if (!differ && rnz) begin
                    res = i_stage.meta.nx ? ay_m_rm : rm_m_ay;
                end else begin
                    res = r;
                end
            end
            default: res = '0;
        endcase

        o_by_zero    = i_stage.meta.dz;
        o_overflowed = !i_stage.meta.dz && quot_mode && i_stage.meta.minneg;
        if (o_by_zero || o_overflowed) begin
            o_outcome = '0;
        end else begin
            o_outcome = cid_pkg::sext(res);
        end
    end

endmodule

`default_nettype wire

### rtl/checked_integer_divide_rounding_core.sv
// ----------------------------------------------------------------------------
// checked_integer_divide_rounding_core
// Pipelined signed divider with truncating, floor and ceiling rounding.
//
//   channel   dir   payload                               transfer
//   i_req     in    action, dividend, divisor             valid & ready
//   o_rsp     out   outcome, overflowed, by_zero          valid & ready
//
// One transfer per cycle in and out while the output is not stalled. A result
// passes through WIDTH division cells, one quotient bit each, then the output
// register. When the output register is held and the last cell holds a result,
// the whole chain holds and i_req.ready drops; bubbles in the chain are filled
// while the output waits to be emptied. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_divide_rounding_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cid_req_if.sink    i_req,
    cid_rsp_if.source  o_rsp
);

    cid_pkg::t_stage   chain [cid_pkg::WIDTH+1];
    logic              en;
    logic [63:0]       outcome;
    logic              overflowed;
    logic              by_zero;

    logic              r_valid;
    logic [63:0]       r_outcome;
    logic              r_overflowed;
    logic              r_by_zero;

    // Advance unless the output holds an untaken result and the last cell holds a valid result.
    assign en          = !r_valid || o_rsp.ready || !chain[cid_pkg::WIDTH].valid;
    assign i_req.ready = en;

    cid_front u_front (
        .i_valid    (i_req.valid),
        .i_action   (i_req.action),
        .i_dividend (i_req.dividend),
        .i_divisor  (i_req.divisor),
        .o_stage    (chain[0])
    );

    for (genvar k = 0; k < cid_pkg::WIDTH; k++) begin : g_cell
        cid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[k]),
            .o_stage (chain[k+1])
        );
    end

    cid_back u_back (
        .i_stage      (chain[cid_pkg::WIDTH]),
        .o_outcome    (outcome),
        .o_overflowed (overflowed),
        .o_by_zero    (by_zero)
    );

    logic out_load;
    assign out_load = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_load) begin
            r_valid <= chain[cid_pkg::WIDTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_outcome    <= outcome;
            r_overflowed <= overflowed;
            r_by_zero    <= by_zero;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.outcome    = r_outcome;
    assign o_rsp.overflowed = r_overflowed;
    assign o_rsp.by_zero    = r_by_zero;

endmodule

`default_nettype wire

### rtl/cid_checker.sv
// ----------------------------------------------------------------------------
// cid_checker
// Port-level checks of the rounding divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cid_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [63:0] i_rsp_outcome,
    input wire logic        i_rsp_overflowed,
    input wire logic        i_rsp_by_zero
);

    `CID_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_rsp_valid)
    `CID_ASSERT(a_zero_div,
        (i_rsp_valid && i_rsp_by_zero) |-> ((i_rsp_outcome == '0) && !i_rsp_overflowed))
    `CID_ASSERT(a_ovf_zero, (i_rsp_valid && i_rsp_overflowed) |-> (i_rsp_outcome == '0))
    `CID_ASSERT(a_hold_val,
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_outcome)))

endmodule

bind checked_integer_divide_rounding_core cid_checker u_cid_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_outcome    (o_rsp.outcome),
    .i_rsp_overflowed (o_rsp.overflowed),
    .i_rsp_by_zero    (o_rsp.by_zero)
);

`default_nettype wire

### dv/checked_integer_divide_rounding_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_divide_rounding_core_tb
// Drives operand pairs with every rounding mode through the pipelined divider.
// Each transfer is predicted at the bit level and compared in order, under
// bursty input, random and patterned output stalls and long output hold-offs.
// ----------------------------------------------------------------------------

module checked_integer_divide_rounding_core_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 4 * (cid_pkg::WIDTH + 1);
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = cid_pkg::WIDTH + 8;

    typedef struct {
        cid_pkg::t_action action;
        logic [63:0]      dividend;
        logic [63:0]      divisor;
    } t_request;

    typedef struct {
        logic [63:0] outcome;
        logic        overflowed;
        logic        by_zero;
    } t_expect;

    class divide_scoreboard;
        t_expect pending_results[$];
        int      errors;

        function t_expect divide_with_rounding(cid_pkg::t_action act, logic [63:0] dividend,
                                               logic [63:0] divisor);
            cid_pkg::t_word                   x, y, ax, ay, qm, rm, q, r, res;
            logic                             nx, ny, differ, minneg;
            logic signed [cid_pkg::WIDTH-1:0] sres;
            t_expect                          e;
            x  = dividend[cid_pkg::WIDTH-1:0];
            y  = divisor[cid_pkg::WIDTH-1:0];
            nx = x[cid_pkg::WIDTH-1];
            ny = y[cid_pkg::WIDTH-1];
            ax = nx ? -x : x;
            ay = ny ? -y : y;
            res          = '0;
            e.overflowed = 1'b0;
            e.by_zero    = 1'b0;
            if (ay == '0) begin
                e.by_zero = 1'b1;
            end else if (act <= cid_pkg::ACT_CEIL_R) begin
                qm     = ax / ay;
                rm     = ax % ay;
                differ = nx ^ ny;
                q      = differ ? -qm : qm;
                r      = nx ? -rm : rm;
                minneg = nx && ny && (ax == {1'b1, {(cid_pkg::WIDTH-1){1'b0}}})
                      && (ay == cid_pkg::t_word'(1));
                if (act <= cid_pkg::ACT_CEIL_Q && minneg) begin
                    e.overflowed = 1'b1;
                end else begin
                    case (act)
                        cid_pkg::ACT_TRUNC_Q: res = q;
                        cid_pkg::ACT_FLOOR_Q: res = (differ && rm != '0) ? q - 1'b1 : q;
                        cid_pkg::ACT_CEIL_Q:  res = (!differ && rm != '0) ? q + 1'b1 : q;
                        cid_pkg::ACT_FLOOR_R: res = (differ && rm != '0) ? r + y : r;
                        default:              res = (!differ && rm != '0) ? r - y : r;
                    endcase
                end
            end
            sres      = res;
            e.outcome = 64'(sres);
            return e;
        endfunction

        function void note_request(cid_pkg::t_action act, logic [63:0] dividend,
                                   logic [63:0] divisor);
            pending_results.push_back(divide_with_rounding(act, dividend, divisor));
        endfunction

        function void check_result(logic [63:0] outcome, logic overflowed, logic by_zero);
            t_expect e;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: outcome=%0d ovf=%0b dz=%0b",
                             $signed(outcome), overflowed, by_zero);
                return;
            end
            e = pending_results.pop_front();
            if (outcome !== e.outcome || overflowed !== e.overflowed
                || by_zero !== e.by_zero) begin
                errors++;
                if (errors <= 10)
                    $display(
                        "mismatch: exp outcome=%0d ovf=%0b dz=%0b got outcome=%0d ovf=%0b dz=%0b",
                        $signed(e.outcome), e.overflowed, e.by_zero,
                        $signed(outcome), overflowed, by_zero);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void close_out();
            if (pending_results.size() != 0) begin
                errors += pending_results.size();
                $display("%0d results never arrived", pending_results.size());
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;

    cid_req_if req_if();
    cid_rsp_if rsp_if();

    checked_integer_divide_rounding_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    divide_scoreboard sb = new();
    t_request         directed_items[$];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.action, req_if.dividend, req_if.divisor);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.outcome, rsp_if.overflowed, rsp_if.by_zero);
        end
    end

    function automatic logic [63:0] most_negative();
        logic signed [cid_pkg::WIDTH-1:0] lo;
        logic signed [63:0]               v;
        lo = {1'b1, {(cid_pkg::WIDTH-1){1'b0}}};
        v  = lo;
        return v;
    endfunction

    function automatic logic [63:0] random_operand(bit is_divisor);
        logic signed [63:0] v;
        logic signed [63:0] lo;
        int                 small_val;
        lo = most_negative();
        case ($urandom_range(0, 9))
            0, 1, 2: v = {$urandom, $urandom};
            3, 4: begin
                v = {$urandom, $urandom};
                v = v >>> $urandom_range(0, 63);
            end
            5: begin
                small_val = $urandom_range(0, 40);
                v = 64'(small_val - 20);
            end
            6: begin
                case ($urandom_range(0, 5))
                    0:       v = lo;
                    1:       v = lo + 64'sd1;
                    2:       v = ~lo;
                    3:       v = -64'sd1;
                    4:       v = 64'sd0;
                    default: v = 64'sd1;
                endcase
            end
            7:       v = is_divisor ? 64'sd0 : {$urandom, $urandom};
            8:       v = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
            default: begin
                v = 64'sd1 <<< $urandom_range(0, cid_pkg::WIDTH - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic t_request random_request();
        t_request           rq;
        logic signed [63:0] d;
        int                 k;
        if ($urandom_range(0, 19) < 18)
            rq.action = cid_pkg::t_action'($urandom_range(cid_pkg::ACT_TRUNC_Q,
                                                          cid_pkg::ACT_CEIL_R));
        else
            rq.action = cid_pkg::t_action'($urandom_range(cid_pkg::ACT_CEIL_R + 1,
                                                          (1 << cid_pkg::ACTION_W) - 1));
        rq.divisor = random_operand(1'b1);
        if ($urandom_range(0, 7) == 0) begin
            d = rq.divisor;
            k = $urandom_range(0, 2000);
            k = k - 1000;
            rq.dividend = d * k;
        end else begin
            rq.dividend = random_operand(1'b0);
        end
        return rq;
    endfunction

    function automatic void add_directed(cid_pkg::t_action act, logic [63:0] a,
                                         logic [63:0] b);
        t_request rq;
        rq.action   = act;
        rq.dividend = a;
        rq.divisor  = b;
        directed_items.push_back(rq);
    endfunction

    task automatic drive_item(input t_request rq);
        req_if.valid    <= 1'b1;
        req_if.action   <= rq.action;
        req_if.dividend <= rq.dividend;
        req_if.divisor  <= rq.divisor;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    task automatic build_directed();
        logic [63:0] lo;
        lo = most_negative();
        add_directed(cid_pkg::ACT_TRUNC_Q, -64'sd7, 64'sd2);
        add_directed(cid_pkg::ACT_FLOOR_Q, 64'sd7, -64'sd2);
        add_directed(cid_pkg::ACT_FLOOR_Q, -64'sd7, -64'sd2);
        add_directed(cid_pkg::ACT_CEIL_Q, 64'sd7, 64'sd2);
        add_directed(cid_pkg::ACT_CEIL_Q, -64'sd7, 64'sd2);
        add_directed(cid_pkg::ACT_FLOOR_R, -64'sd7, 64'sd2);
        add_directed(cid_pkg::ACT_FLOOR_R, 64'sd7, 64'sd2);
        add_directed(cid_pkg::ACT_CEIL_R, 64'sd7, 64'sd2);
        add_directed(cid_pkg::ACT_CEIL_R, 64'sd7, -64'sd2);
        for (int a = cid_pkg::ACT_TRUNC_Q; a <= cid_pkg::ACT_CEIL_R; a++)
            add_directed(cid_pkg::t_action'(a), lo, -64'sd1);
        add_directed(cid_pkg::ACT_TRUNC_Q, 64'sd5, 64'sd0);
        add_directed(cid_pkg::ACT_FLOOR_R, lo, 64'sd0);
        add_directed(cid_pkg::t_action'(cid_pkg::ACT_CEIL_R + 1), 64'sd9, 64'sd0);
        add_directed(cid_pkg::t_action'(cid_pkg::ACT_CEIL_R + 2), 64'sd9, 64'sd3);
        add_directed(cid_pkg::t_action'((1 << cid_pkg::ACTION_W) - 1), lo, -64'sd1);
        add_directed(cid_pkg::ACT_TRUNC_Q, ~lo, 64'sd1);
        add_directed(cid_pkg::ACT_FLOOR_Q, lo, ~lo);
        add_directed(cid_pkg::ACT_CEIL_Q, ~lo, lo);
        add_directed(cid_pkg::ACT_TRUNC_Q, lo, lo);
        add_directed(cid_pkg::ACT_CEIL_R, -64'sd1, ~lo);
        add_directed(cid_pkg::ACT_FLOOR_Q, 64'sd0, -64'sd5);
    endtask

    // output side: random stall patterns with periodic long hold-offs
    initial begin : receiver
        int seg;
        int len;
        int mode;
        int period;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        seg = 0;
        forever begin
            if (seg % 9 == 2) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode   = $urandom_range(0, 3);
                len    = $urandom_range(10, 150);
                period = $urandom_range(2, 6);
                for (int k = 0; k < len; k++) begin
                    case (mode)
                        0:       rsp_if.ready <= 1'b1;
                        1:       rsp_if.ready <= $urandom_range(0, 1);
                        2:       rsp_if.ready <= (k % period) != 0;
                        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    initial begin : sender
        t_request rq;
        int       sent;
        int       total;
        int       burst;
        int       gap;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.action   <= cid_pkg::ACT_TRUNC_Q;
        req_if.dividend <= '0;
        req_if.divisor  <= '0;
        build_directed();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        total = directed_items.size() + RANDOM_ITEMS;
        sent  = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && sent < total) begin
                if (sent < directed_items.size())
                    rq = directed_items[sent];
                else
                    rq = random_request();
                drive_item(rq);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/cid_pkg.sv
rtl/cid_if.sv
rtl/cid_front.sv
rtl/cid_cell.sv
rtl/cid_back.sv
rtl/checked_integer_divide_rounding_core.sv
rtl/cid_checker.sv
dv/checked_integer_divide_rounding_core_tb.sv
